// ----- design/utf8_percent_encoder_defines.svh -----
// assertion macros shared by the utf8 percent encoder
// depends on: nothing; users supply a clk and rst_n in scope
`ifndef UTF8_PERCENT_ENCODER_DEFINES_SVH
`define UTF8_PERCENT_ENCODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/upe_pkg.sv -----
// shared types, constants and helper functions of the utf8 percent encoder
// depends on: nothing
package upe_pkg;

  localparam int CP_W      = 21;
  localparam int CHAR_W    = 7;
  localparam int MAX_CHARS = 12;
  localparam int CNT_W     = 4;

  localparam logic [CHAR_W-1:0] CHAR_PCT = 7'h25;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [MAX_CHARS-1:0] char_buf_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one encoded code point: characters in emit order from index 0
  typedef struct packed {
    char_buf_t chars;
    cnt_t      count;
  } enc_t;

  function automatic logic byte_kept(input logic [7:0] b);
    byte_kept = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                           8'h2A, 8'h2D, 8'h2E, 8'h5F});
  endfunction

  function automatic char_t hex_digit(input logic [3:0] n);
    hex_digit = (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h37 + {3'b000, n});
  endfunction

endpackage

// ----- design/upe_encode.sv -----
// combinational utf8 encode plus percent escape of one code point
// depends on: upe_pkg
module upe_encode (
  input  logic [upe_pkg::CP_W-1:0] cp,
  output upe_pkg::enc_t            enc
);

  logic [3:0][7:0] utf8_b;
  logic [2:0]      nb;
  upe_pkg::cnt_t   pos;

  // utf8 byte split, byte 0 first
  always_comb begin
    utf8_b = '0;
    if (cp < 21'h80) begin
      nb        = 3'd1;
      utf8_b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      nb        = 3'd2;
      utf8_b[0] = {3'b110, cp[10:6]};
      utf8_b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      nb        = 3'd3;
      utf8_b[0] = {4'b1110, cp[15:12]};
      utf8_b[1] = {2'b10, cp[11:6]};
      utf8_b[2] = {2'b10, cp[5:0]};
    end else begin
      nb        = 3'd4;
      utf8_b[0] = {5'b11110, cp[20:18]};
      utf8_b[1] = {2'b10, cp[17:12]};
      utf8_b[2] = {2'b10, cp[11:6]};
      utf8_b[3] = {2'b10, cp[5:0]};
    end
  end

  // pack kept bytes or three-char escapes back to back
  always_comb begin
    enc = '0;
    pos = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nb) begin
        if (upe_pkg::byte_kept(utf8_b[i])) begin
          enc.chars[pos] = utf8_b[i][6:0];
          pos            = pos + 4'd1;
        end else begin
          enc.chars[pos]        = upe_pkg::CHAR_PCT;
          enc.chars[pos + 4'd1] = upe_pkg::hex_digit(utf8_b[i][7:4]);
          enc.chars[pos + 4'd2] = upe_pkg::hex_digit(utf8_b[i][3:0]);
          pos                   = pos + 4'd3;
        end
      end
    end
    enc.count = pos;
  end

endmodule

// ----- design/utf8_percent_encoder.sv -----
// top level of the utf8 percent encoder: input register, encode, output shifter
// depends on: upe_pkg, upe_encode, utf8_percent_encoder_defines.svh
`include "utf8_percent_encoder_defines.svh"

// One code point per transfer in, one ASCII character per cycle out. A code
// point is accepted when start is high and busy is low; it gives 1 to 12
// characters (kept bytes pass as themselves, other bytes become '%' and two
// uppercase hex digits), which appear on out_char on consecutive cycles with
// out_valid high, the final one flagged by out_last_of_run. When the output
// stage is free, an accepted item goes from the input register into the output
// shift register, whose first slot drives out_char. The receiver cannot stall:
// every cycle with out_valid high is a transfer. Throughput is set by the
// single output character port, so an item holds the output until all of its
// characters (1 to 12) have gone out; the next item waits in the input
// register and is taken while the previous run drains, so single-character items
// flow at one per cycle.
module utf8_percent_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [upe_pkg::CP_W-1:0]    in_code_point,
  output logic                        out_valid,
  output logic [upe_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last_of_run
);

  // input register stage
  logic                     a_valid_r, a_valid_nxt;
  logic [upe_pkg::CP_W-1:0] a_cp_r;

  // output shift stage: chars_r[0] is on the port
  logic                 b_valid_r, b_valid_nxt;
  upe_pkg::char_buf_t   chars_r, chars_nxt;
  upe_pkg::cnt_t        rem_r, rem_nxt;

  upe_pkg::enc_t enc;
  logic          accept;
  logic          b_done;
  logic          b_load;

  upe_encode u_encode (
    .cp  (a_cp_r),
    .enc (enc)
  );

  // output stage frees up after its last character this cycle
  assign b_done = !b_valid_r || (rem_r == 4'd1);
  assign b_load = a_valid_r && b_done;
  // input register can take a new item whenever it is empty or empties this cycle
  assign busy   = a_valid_r && !b_done;
  assign accept = start && !busy;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    rem_nxt     = rem_r;
    chars_nxt   = chars_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
      rem_nxt     = enc.count;
      chars_nxt   = enc.chars;
    end else if (b_valid_r) begin
      // shift the run down by one transfer
      b_valid_nxt = !b_done;
      rem_nxt     = rem_r - 4'd1;
      for (int k = 0; k < upe_pkg::MAX_CHARS - 1; k++) begin
        chars_nxt[k] = chars_r[k + 1];
      end
      chars_nxt[upe_pkg::MAX_CHARS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      a_cp_r <= in_code_point;
    end
    chars_r <= chars_nxt;
  end

  assign out_valid       = b_valid_r;
  assign out_char        = chars_r[0];
  assign out_last_of_run = b_valid_r && (rem_r == 4'd1);

  // a run in progress never has zero or more than twelve characters left
  `UPE_ASSERT_NOW(a_rem_range, b_valid_r,
                  (rem_r != 4'd0) && (rem_r <= 4'd12), "remaining count out of range")
  // a run keeps going until its last character
  `UPE_ASSERT_NEXT(a_run_cont, out_valid && !out_last_of_run,
                   out_valid, "run broke off before last character")
  // with nothing queued the output goes quiet after the last character
  `UPE_ASSERT_NEXT(a_run_end, out_valid && out_last_of_run && !a_valid_r,
                   !out_valid, "output continued with no queued item")
  // an accepted item is held until the output stage takes it
  `UPE_ASSERT_NEXT(a_hold_item, start && !busy, a_valid_r, "accepted item lost")

endmodule
